/* rtl/colz_pkg.sv */
// shared types, constants and field widths of the point colorizer
package colz_pkg;

  localparam int ImagePixelsDefault = 524288;

  // camera coordinate, projection numerator, denominator and quotient widths
  localparam int CW = 37;
  localparam int NW = 55;
  localparam int DW = 40;
  localparam int QW = 12;
  localparam int RW = DW + QW;

  localparam logic [24:0] FrameReset = 25'd1966720;

  localparam logic [7:0] ColDim  = 8'd55;
  localparam logic [7:0] ColMid  = 8'd100;
  localparam logic [7:0] ColFull = 8'd255;

  typedef enum logic {
    OpPixel = 1'b0,
    OpPoint = 1'b1
  } colz_op_e;

  typedef enum logic [2:0] {
    RegR00R01 = 3'd0,
    RegR02T0  = 3'd1,
    RegR10R11 = 3'd2,
    RegR12T1  = 3'd3,
    RegR20R21 = 3'd4,
    RegR22T2  = 3'd5,
    RegIntr   = 3'd6,
    RegFrame  = 3'd7
  } colz_reg_e;

  typedef struct packed {
    colz_op_e    op;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [18:0] pix_idx;
    logic [23:0] bgr;
  } colz_item_t;

  typedef struct packed {
    logic [2:0][2:0][31:0] rot;
    logic [2:0][31:0]      trans;
    logic [15:0]           fx;
    logic [15:0]           fy;
    logic [15:0]           cx;
    logic [15:0]           cy;
    logic [11:0]           width;
    logic [11:0]           height;
    logic                  feature;
  } colz_cfg_t;

  typedef struct packed {
    logic          pass;
    logic [DW-1:0] den;
    logic [RW-1:0] rem_u;
    logic [RW-1:0] rem_v;
    logic [QW-1:0] q_u;
    logic [QW-1:0] q_v;
  } colz_div_t;

endpackage

/* rtl/colz_transform.sv */
// rigid extrinsic transform: product stage and sum stage
module colz_transform (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    adv_i,
  input  colz_pkg::colz_cfg_t                     cfg_i,
  input  logic                                    vld_i,
  input  colz_pkg::colz_item_t                    item_i,
  output logic                                    vld_o,
  output colz_pkg::colz_item_t                    item_o,
  output logic [2:0][colz_pkg::CW-1:0]            cam_o
);
  import colz_pkg::*;

  function automatic logic signed [63:0] smul32(logic signed [31:0] a, logic signed [31:0] b);
    smul32 = a * b;
  endfunction

  logic [2:0][31:0]       pt;
  logic [2:0][2:0][63:0]  prod_d, prod_q;
  logic [2:0][65:0]       sum_c;
  logic [2:0][CW-1:0]     cam_d, cam_q;
  logic                   vld1_q, vld2_q;
  colz_item_t             item1_q, item2_q;

  assign pt = {item_i.pz, item_i.py, item_i.px};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = smul32(cfg_i.rot[i][j], pt[j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_c[i] = 66'($signed(prod_q[i][0])) + 66'($signed(prod_q[i][1]))
               + 66'($signed(prod_q[i][2]));
      cam_d[i] = CW'($signed(sum_c[i][65:30])) + CW'($signed(cfg_i.trans[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (adv_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q  <= prod_d;
      item1_q <= item_i;
      cam_q   <= cam_d;
      item2_q <= item1_q;
    end
  end

  assign vld_o  = vld2_q;
  assign item_o = item2_q;
  assign cam_o  = cam_q;

endmodule

/* rtl/colz_project.sv */
// pinhole projection: numerator products, sums, and range precheck for division
module colz_project (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  colz_pkg::colz_cfg_t          cfg_i,
  input  logic                         vld_i,
  input  colz_pkg::colz_item_t         item_i,
  input  logic [2:0][colz_pkg::CW-1:0] cam_i,
  output logic                         vld_o,
  output colz_pkg::colz_item_t         item_o,
  output colz_pkg::colz_div_t          div_o
);
  import colz_pkg::*;

  logic signed [53:0] mfx_d, mcx_d, mfy_d, mcy_d;
  logic signed [53:0] mfx_q, mcx_q, mfy_q, mcy_q;
  logic               ok_d, ok3_q, ok4_q;
  logic [DW-1:0]      den_d, den3_q, den4_q;
  logic [1:0][NW-1:0] num_d, num_q;
  logic [NW-1:0]      den_sh;
  logic [1:0][NW-1:0] mag;
  logic [1:0]         fit;
  colz_div_t          div_d, div_q;
  logic               vld3_q, vld4_q, vld5_q;
  colz_item_t         item3_q, item4_q, item5_q;

  // stage 3: products with the intrinsics
  always_comb begin
    mfx_d = $signed({1'b0, cfg_i.fx}) * $signed(cam_i[0]);
    mcx_d = $signed({1'b0, cfg_i.cx}) * $signed(cam_i[2]);
    mfy_d = $signed({1'b0, cfg_i.fy}) * $signed(cam_i[1]);
    mcy_d = $signed({1'b0, cfg_i.cy}) * $signed(cam_i[2]);
    ok_d  = ($signed(cam_i[2]) > 0) && !(cfg_i.feature && ($signed(item_i.px) <= 0));
    den_d = {cam_i[2][DW-5:0], 4'b0000};
  end

  // stage 4: numerators
  always_comb begin
    num_d[0] = NW'(mfx_q) + NW'(mcx_q);
    num_d[1] = NW'(mfy_q) + NW'(mcy_q);
  end

  // stage 5: quotient must fit in the quotient width, negatives only round to zero
  always_comb begin
    den_sh = NW'({den4_q, {QW{1'b0}}});
    div_d  = '0;
    for (int k = 0; k < 2; k++) begin
      mag[k] = -num_q[k];
      if (num_q[k][NW-1]) begin
        fit[k] = mag[k] < NW'(den4_q);
      end else begin
        fit[k] = num_q[k] < den_sh;
      end
    end
    div_d.pass  = ok4_q && fit[0] && fit[1];
    div_d.den   = den4_q;
    div_d.rem_u = num_q[0][NW-1] ? '0 : num_q[0][RW-1:0];
    div_d.rem_v = num_q[1][NW-1] ? '0 : num_q[1][RW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
    end else if (adv_i) begin
      vld3_q <= vld_i;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mfx_q   <= mfx_d;
      mcx_q   <= mcx_d;
      mfy_q   <= mfy_d;
      mcy_q   <= mcy_d;
      ok3_q   <= ok_d;
      den3_q  <= den_d;
      item3_q <= item_i;
      num_q   <= num_d;
      ok4_q   <= ok3_q;
      den4_q  <= den3_q;
      item4_q <= item3_q;
      div_q   <= div_d;
      item5_q <= item4_q;
    end
  end

  assign vld_o  = vld5_q;
  assign item_o = item5_q;
  assign div_o  = div_q;

endmodule

/* rtl/colz_divider.sv */
// restoring divider, one quotient bit of column and row per stage
module colz_divider (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 vld_i,
  input  colz_pkg::colz_item_t item_i,
  input  colz_pkg::colz_div_t  div_i,
  output logic                 vld_o,
  output colz_pkg::colz_item_t item_o,
  output colz_pkg::colz_div_t  div_o
);
  import colz_pkg::*;

  logic       vld_w  [QW+1];
  colz_item_t item_w [QW+1];
  colz_div_t  div_w  [QW+1];

  assign vld_w[0]  = vld_i;
  assign item_w[0] = item_i;
  assign div_w[0]  = div_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int Sh = QW - 1 - k;
    logic          vld_q;
    colz_item_t    item_q;
    colz_div_t     div_d, div_q;
    logic [RW-1:0] dsh;

    always_comb begin
      div_d = div_w[k];
      dsh   = RW'(div_w[k].den) << Sh;
      if (div_d.rem_u >= dsh) begin
        div_d.rem_u   = div_d.rem_u - dsh;
        div_d.q_u[Sh] = 1'b1;
      end
      if (div_d.rem_v >= dsh) begin
        div_d.rem_v   = div_d.rem_v - dsh;
        div_d.q_v[Sh] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (adv_i) begin
        vld_q <= vld_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        item_q <= item_w[k];
        div_q  <= div_d;
      end
    end

    assign vld_w[k+1]  = vld_q;
    assign item_w[k+1] = item_q;
    assign div_w[k+1]  = div_q;
  end

  assign vld_o  = vld_w[QW];
  assign item_o = item_w[QW];
  assign div_o  = div_w[QW];

endmodule

/* rtl/colz_lookup.sv */
// image bound check, pixel address, image store and color choice
module colz_lookup #(
  parameter int ImagePixels = colz_pkg::ImagePixelsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  colz_pkg::colz_cfg_t  cfg_i,
  input  logic                 vld_i,
  input  colz_pkg::colz_item_t item_i,
  input  colz_pkg::colz_div_t  div_i,
  output logic                 out_valid_o,
  output logic                 kept_o,
  output logic [31:0]          out_x_o,
  output logic [31:0]          out_y_o,
  output logic [31:0]          out_z_o,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o,
  output logic [11:0]          column_o,
  output logic [11:0]          row_o
);
  import colz_pkg::*;

  localparam int AW = $clog2(ImagePixels);

  logic          vld18_q, vld19_q, vld20_q, out_vld_q;
  colz_item_t    item18_q, item19_q, item20_q;
  logic          inr_d, inr18_q;
  logic [23:0]   prod_d, prod18_q;
  logic [QW-1:0] qu18_q, qv18_q, qu19_q, qv19_q, qu20_q, qv20_q;
  logic [23:0]   addr_d, addr19_q;
  logic          keep_d, keep19_q, keep20_q;
  logic [31:0]   widx_ext, ridx_ext;
  logic [AW-1:0] waddr, raddr;
  logic          wr_en;
  logic [23:0]   image_q [ImagePixels];
  logic [23:0]   rd_q;
  logic [7:0]    pb, pg, pr;
  logic [7:0]    red_d, green_d, blue_d;
  logic [11:0]   col_d, row_d;
  logic          mark;
  logic          kept_q;
  logic [31:0]   x_q, y_q, z_q;
  logic [7:0]    red_q, green_q, blue_q;
  logic [11:0]   col_q, row_q;

  always_comb begin
    inr_d  = div_i.pass && (div_i.q_u < cfg_i.width) && (div_i.q_v < cfg_i.height);
    prod_d = 24'(div_i.q_v) * 24'(cfg_i.width);
  end

  always_comb begin
    addr_d = prod18_q + 24'(qu18_q);
    keep_d = inr18_q && (32'(addr_d) < 32'(ImagePixels));
  end

  // writes and reads happen at the same stage, so they stay in arrival order
  always_comb begin
    widx_ext = 32'(item19_q.pix_idx);
    ridx_ext = 32'(addr19_q);
    waddr    = widx_ext[AW-1:0];
    raddr    = ridx_ext[AW-1:0];
    wr_en    = adv_i && vld19_q && (item19_q.op == OpPixel)
               && (widx_ext < 32'(ImagePixels));
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      image_q[waddr] <= item19_q.bgr;
    end
    if (adv_i) begin
      rd_q <= image_q[raddr];
    end
  end

  always_comb begin
    pb      = rd_q[23:16];
    pg      = rd_q[15:8];
    pr      = rd_q[7:0];
    mark    = ((pb == ColFull) && (pr == ColDim)) || ((pb == ColDim) && (pr == ColFull));
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    col_d   = '0;
    row_d   = '0;
    if (keep20_q) begin
      col_d = qu20_q;
      row_d = qv20_q;
      if (!cfg_i.feature) begin
        red_d   = pr;
        green_d = pg;
        blue_d  = pb;
      end else if (mark) begin
        red_d   = pr;
        green_d = ColDim;
        blue_d  = pb;
      end else begin
        red_d   = ColDim;
        green_d = ColMid;
        blue_d  = ColDim;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld18_q   <= 1'b0;
      vld19_q   <= 1'b0;
      vld20_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv_i) begin
      vld18_q   <= vld_i;
      vld19_q   <= vld18_q;
      vld20_q   <= vld19_q;
      out_vld_q <= vld20_q && (item20_q.op == OpPoint);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item18_q <= item_i;
      inr18_q  <= inr_d;
      prod18_q <= prod_d;
      qu18_q   <= div_i.q_u;
      qv18_q   <= div_i.q_v;
      item19_q <= item18_q;
      addr19_q <= addr_d;
      keep19_q <= keep_d;
      qu19_q   <= qu18_q;
      qv19_q   <= qv18_q;
      item20_q <= item19_q;
      keep20_q <= keep19_q;
      qu20_q   <= qu19_q;
      qv20_q   <= qv19_q;
      kept_q   <= keep20_q;
      x_q      <= item20_q.px;
      y_q      <= item20_q.py;
      z_q      <= item20_q.pz;
      red_q    <= red_d;
      green_q  <= green_d;
      blue_q   <= blue_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign kept_o      = kept_q;
  assign out_x_o     = x_q;
  assign out_y_o     = y_q;
  assign out_z_o     = z_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign column_o    = col_q;
  assign row_o       = row_q;

endmodule

/* rtl/lidar_point_camera_colorizer.sv */
// top level of the lidar point colorizer: config registers, pipeline control
//
// Input channel (in_valid_i / in_stall_o): op_i 0 writes pixel_bgr_i into the
// image store at pixel_index_i and gives no result; op_i 1 projects the point
// point_x/y/z_i through the extrinsic transform and the pinhole intrinsics.
// Output channel (out_valid_o / out_stall_i): one word per point with the
// point passed through, the kept flag, the pixel position and the color.
// Config port: cfg_we_i writes cfg_data_i into register cfg_index_i; write
// only while no word is in flight.
// Throughput: one word per cycle while the output is not stalled. From
// acceptance to the output register: 2 transform stages, 3 projection
// stages, 12 divider stages producing one quotient bit each, 4 lookup stages.
// Pixel writes and point reads hit the image store at the same stage, so a
// point sees every write accepted before it.
// Reset clears the pipeline valid bits and the config registers (frame
// 640 x 480, map mode); image store contents are undefined until written.
// A stall while out_valid_o is high freezes the whole pipeline and raises in_stall_o.
module lidar_point_camera_colorizer #(
  parameter int ImagePixels = colz_pkg::ImagePixelsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic [18:0]        pixel_index_i,
  input  logic [23:0]        pixel_bgr_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kept_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [11:0]        column_o,
  output logic [11:0]        row_o
);
  import colz_pkg::*;

  logic [6:0][63:0]   regs_q;
  logic [24:0]        frame_q;
  colz_cfg_t          cfg;
  logic               adv;
  colz_item_t         item_in;
  logic               tr_vld, pj_vld, dv_vld;
  colz_item_t         tr_item, pj_item, dv_item;
  logic [2:0][CW-1:0] cam;
  colz_div_t          pj_div, dv_div;
  logic [31:0]        ox, oy, oz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q  <= '0;
      frame_q <= FrameReset;
    end else if (cfg_we_i) begin
      unique case (colz_reg_e'(cfg_index_i))
        RegR00R01, RegR02T0, RegR10R11, RegR12T1,
        RegR20R21, RegR22T2, RegIntr: begin
          regs_q[cfg_index_i] <= cfg_data_i;
        end
        RegFrame: begin
          frame_q <= cfg_data_i[24:0];
        end
        default: begin
          frame_q <= frame_q;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cfg.rot[i][0] = regs_q[2*i][63:32];
      cfg.rot[i][1] = regs_q[2*i][31:0];
      cfg.rot[i][2] = regs_q[2*i+1][63:32];
      cfg.trans[i]  = regs_q[2*i+1][31:0];
    end
    cfg.fx      = regs_q[RegIntr][63:48];
    cfg.fy      = regs_q[RegIntr][47:32];
    cfg.cx      = regs_q[RegIntr][31:16];
    cfg.cy      = regs_q[RegIntr][15:0];
    cfg.width   = frame_q[11:0];
    cfg.height  = frame_q[23:12];
    cfg.feature = frame_q[24];
  end

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  always_comb begin
    item_in.op      = colz_op_e'(op_i);
    item_in.px      = point_x_i;
    item_in.py      = point_y_i;
    item_in.pz      = point_z_i;
    item_in.pix_idx = pixel_index_i;
    item_in.bgr     = pixel_bgr_i;
  end

  colz_transform u_transform (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .cfg_i  (cfg),
    .vld_i  (in_valid_i),
    .item_i (item_in),
    .vld_o  (tr_vld),
    .item_o (tr_item),
    .cam_o  (cam)
  );

  colz_project u_project (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .cfg_i  (cfg),
    .vld_i  (tr_vld),
    .item_i (tr_item),
    .cam_i  (cam),
    .vld_o  (pj_vld),
    .item_o (pj_item),
    .div_o  (pj_div)
  );

  colz_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (pj_vld),
    .item_i (pj_item),
    .div_i  (pj_div),
    .vld_o  (dv_vld),
    .item_o (dv_item),
    .div_o  (dv_div)
  );

  colz_lookup #(
    .ImagePixels (ImagePixels)
  ) u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .cfg_i       (cfg),
    .vld_i       (dv_vld),
    .item_i      (dv_item),
    .div_i       (dv_div),
    .out_valid_o (out_valid_o),
    .kept_o      (kept_o),
    .out_x_o     (ox),
    .out_y_o     (oy),
    .out_z_o     (oz),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .column_o    (column_o),
    .row_o       (row_o)
  );

  assign out_x_o = ox;
  assign out_y_o = oy;
  assign out_z_o = oz;

  a_kept_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kept_o |-> (column_o < cfg.width) && (row_o < cfg.height))
    else $error("kept point outside frame");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kept_o |-> (red_o == '0) && (green_o == '0) && (blue_o == '0)
                              && (column_o == '0) && (row_o == '0))
    else $error("dropped point carries nonzero fields");

  a_feature_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kept_o && cfg.feature |-> (green_o == ColDim) || (green_o == ColMid))
    else $error("feature mode green out of set");

endmodule
